// ===== hw/rtl/anss_pkg.sv =====
package anss_pkg;

    localparam int ANSS_POSITION_BITS = 24;
    localparam int ANSS_FIELD_W       = 24;
    localparam logic [ANSS_FIELD_W-1:0] ANSS_FIELD_MAX = '1;

    // span queue: room for two spans from one byte plus slack for a stalled receiver
    localparam int ANSS_QUEUE_DEPTH = 4;
    localparam int ANSS_PTR_W       = $clog2(ANSS_QUEUE_DEPTH);
    localparam int ANSS_CNT_W       = $clog2(ANSS_QUEUE_DEPTH + 1);

    typedef struct packed {
        logic [ANSS_FIELD_W-1:0] unit_offset;
        logic [ANSS_FIELD_W-1:0] unit_length;
        logic                    run_last;
        logic                    position_overflow;
    } t_span;

    typedef struct packed {
        logic first;
        logic second;
    } t_span_push;

endpackage

// ===== hw/rtl/anss_span_queue.sv =====
module anss_span_queue
    import anss_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_span_push i_push,
    input  t_span      i_span_first,
    input  t_span      i_span_second,
    output logic       o_full,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output t_span      o_span
);

    t_span                 r_mem [ANSS_QUEUE_DEPTH];
    logic [ANSS_PTR_W-1:0] r_wr_ptr;
    logic [ANSS_PTR_W-1:0] r_rd_ptr;
    logic [ANSS_CNT_W-1:0] r_count;
    logic [ANSS_PTR_W-1:0] n_wr_ptr;
    logic [ANSS_PTR_W-1:0] n_rd_ptr;
    logic [ANSS_CNT_W-1:0] n_count;
    logic [ANSS_PTR_W-1:0] wr_ptr_second;
    logic                  pop;

    // a byte may bring two spans, so hold off while fewer than two slots are free
    assign o_full      = r_count > ANSS_CNT_W'(ANSS_QUEUE_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign o_span      = r_mem[r_rd_ptr];
    assign pop         = o_out_valid & ~i_out_stall;

    always_comb begin
        wr_ptr_second = r_wr_ptr + ANSS_PTR_W'(1);
        n_wr_ptr      = r_wr_ptr + ANSS_PTR_W'(i_push.first) + ANSS_PTR_W'(i_push.second);
        n_rd_ptr      = r_rd_ptr + ANSS_PTR_W'(pop);
        n_count       = r_count + ANSS_CNT_W'(i_push.first) + ANSS_CNT_W'(i_push.second)
                        - ANSS_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.first) begin
            r_mem[r_wr_ptr] <= i_span_first;
        end
        if (i_push.second) begin
            r_mem[wr_ptr_second] <= i_span_second;
        end
    end

endmodule

// ===== hw/rtl/annexb_nal_span_scanner.sv =====
// Annex-B start-code scanner: reports the payload span of every unit in a byte stream.
// Input channel: one stream byte per request (i_stream_byte) with i_final_byte set on
// the last byte; a request is taken when i_in_valid is high and o_in_stall is low.
// Output channel: one span per request (offset, length, run_last, position_overflow),
// taken when o_out_valid is high and i_out_stall is low.
// Throughput: one byte per cycle while o_in_stall is low. Each byte is judged by a
// three-byte lookback compare and one saturating position add, straight into a
// four-entry span queue, in which each span is registered and waits behind older spans.
// An ordinary byte yields at most one span, the final byte at most two (the close by a
// start code, then the close at stream end), which drain one per cycle when not stalled.
// When the receiver stalls, spans wait in the queue and bytes keep flowing until fewer
// than two slots are free; then o_in_stall rises until the receiver drains one.
// Reset (synchronous, active low) empties the queue and clears the window, position,
// open-unit and overflow state; no clearing pass is needed. The same scan state also
// returns to reset after every final byte.
module annexb_nal_span_scanner
    import anss_pkg::*;
#(
    parameter int POSITION_BITS = ANSS_POSITION_BITS
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  logic [7:0]              i_stream_byte,
    input  logic                    i_final_byte,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output logic [ANSS_FIELD_W-1:0] o_unit_offset,
    output logic [ANSS_FIELD_W-1:0] o_unit_length,
    output logic                    o_run_last,
    output logic                    o_position_overflow
);

    localparam int WIDE = (POSITION_BITS > ANSS_FIELD_W) ? POSITION_BITS : ANSS_FIELD_W;

    function automatic logic [ANSS_FIELD_W-1:0] clamp_field(input logic [POSITION_BITS-1:0] v);
        logic [WIDE-1:0] w;
        w = WIDE'(v);
        clamp_field = (w > WIDE'(ANSS_FIELD_MAX)) ? ANSS_FIELD_MAX : w[ANSS_FIELD_W-1:0];
    endfunction

    logic [7:0]               r_lb0;
    logic [7:0]               r_lb1;
    logic [7:0]               r_lb2;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_start;
    logic                     r_inside;
    logic                     r_ov;
    logic [1:0]               r_skip;

    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_start;
    logic                     n_inside;
    logic                     n_ov;
    logic [1:0]               n_skip;

    logic                     accept;
    logic                     full;
    logic                     judge;
    logic                     zero2;
    logic                     sc4;
    logic                     sc3;
    logic                     hit;
    logic                     at_max;
    logic [POSITION_BITS-1:0] pos_i;
    logic [POSITION_BITS-1:0] len1;
    logic [POSITION_BITS-1:0] len2;
    logic                     span1;
    logic                     span2;
    t_span                    span_a;
    t_span                    span_b;
    t_span                    span_first;
    t_span                    span_second;
    t_span_push               push;
    t_span                    out_span;

    assign o_in_stall = full;
    assign accept     = i_in_valid & ~full;

    always_comb begin
        at_max = r_pos == '1;
        judge  = (r_pos >= POSITION_BITS'(3)) && (r_skip == 2'd0);
        zero2  = (r_lb0 == 8'd0) && (r_lb1 == 8'd0);
        sc4    = zero2 && (r_lb2 == 8'd0) && (i_stream_byte == 8'd1);
        sc3    = !sc4 && zero2 && (r_lb2 == 8'd1);
        hit    = judge && (sc4 || sc3);
        pos_i  = r_pos - POSITION_BITS'(3);

        // payload starts at i+4 or i+3, i.e. cur+1 (saturating) or cur
        n_start  = hit ? ((sc4 && !at_max) ? r_pos + POSITION_BITS'(1) : r_pos) : r_start;
        n_pos    = at_max ? r_pos : r_pos + POSITION_BITS'(1);
        n_ov     = r_ov | at_max;
        n_inside = r_inside | hit;

        if (hit) begin
            n_skip = sc4 ? 2'd3 : 2'd2;
        end else if (r_skip != 2'd0) begin
            n_skip = r_skip - 2'd1;
        end else begin
            n_skip = r_skip;
        end

        span1 = hit & r_inside;
        span2 = i_final_byte & n_inside;
        len1  = (pos_i >= r_start) ? pos_i - r_start : '0;
        len2  = (n_pos >= n_start) ? n_pos - n_start : '0;

        span_a.unit_offset       = clamp_field(r_start);
        span_a.unit_length       = clamp_field(len1);
        span_a.run_last          = !span2;
        span_a.position_overflow = n_ov;

        span_b.unit_offset       = clamp_field(n_start);
        span_b.unit_length       = clamp_field(len2);
        span_b.run_last          = 1'b1;
        span_b.position_overflow = n_ov;

        span_first  = span1 ? span_a : span_b;
        span_second = span_b;
        push.first  = accept & (span1 | span2);
        push.second = accept & span1 & span2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lb0    <= '0;
            r_lb1    <= '0;
            r_lb2    <= '0;
            r_pos    <= '0;
            r_start  <= '0;
            r_inside <= 1'b0;
            r_ov     <= 1'b0;
            r_skip   <= '0;
        end else if (accept) begin
            if (i_final_byte) begin
                r_lb0    <= '0;
                r_lb1    <= '0;
                r_lb2    <= '0;
                r_pos    <= '0;
                r_start  <= '0;
                r_inside <= 1'b0;
                r_ov     <= 1'b0;
                r_skip   <= '0;
            end else begin
                r_lb0    <= r_lb1;
                r_lb1    <= r_lb2;
                r_lb2    <= i_stream_byte;
                r_pos    <= n_pos;
                r_start  <= n_start;
                r_inside <= n_inside;
                r_ov     <= n_ov;
                r_skip   <= n_skip;
            end
        end
    end

    anss_span_queue u_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_push        (push),
        .i_span_first  (span_first),
        .i_span_second (span_second),
        .o_full        (full),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_span        (out_span)
    );

    assign o_unit_offset       = out_span.unit_offset;
    assign o_unit_length       = out_span.unit_length;
    assign o_run_last          = out_span.run_last;
    assign o_position_overflow = out_span.position_overflow;

endmodule
